[src/chgs_pkg.sv]
// Shared types and constants of the Graham-scan convex hull block.
package chgs_pkg;

  // Default sizes; the top level hands them down as parameters.
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 16;

  // A hull needs at least this many points.
  localparam int unsigned HullMin = 3;

  // Controller states.
  typedef enum logic [5:0] {
    ST_LOAD,
    ST_ECHO_RD,
    ST_ECHO_EMIT,
    ST_BEST_RD,
    ST_BEST_UPD,
    ST_ORD_INIT,
    ST_SORT_RD,
    ST_SORT_PT,
    ST_SORT_LDA,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_LDB,
    ST_INS_W1,
    ST_INS_W2,
    ST_INS_DEC,
    ST_DD_CHK,
    ST_DD_PT,
    ST_DD_LDA,
    ST_DD_NEXT,
    ST_DD_PT2,
    ST_DD_LDB,
    ST_DD_W1,
    ST_DD_W2,
    ST_DD_DEC,
    ST_DEGEN,
    ST_CP_RD,
    ST_CP_WR,
    ST_SC_CHK,
    ST_SC_PT,
    ST_SC_LDB,
    ST_SC_TOP,
    ST_SC_PT0,
    ST_SC_LDO,
    ST_SC_PT1,
    ST_SC_LDA,
    ST_SC_W1,
    ST_SC_W2,
    ST_SC_DEC,
    ST_OUT_RD,
    ST_OUT_PT,
    ST_OUT_EMIT,
    ST_DONE
  } state_e;

  // Source of the point store read address.
  typedef enum logic [1:0] {
    PA_CMD,
    PA_ORD,
    PA_STK
  } pt_sel_e;

  // Source of the order store write data.
  typedef enum logic [1:0] {
    OW_INIT,
    OW_V,
    OW_W,
    OW_U
  } ow_sel_e;

  // Source of the hull stack write data.
  typedef enum logic {
    SW_ORD,
    SW_V
  } sw_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    pt_we;
    logic    pt_re;
    pt_sel_e pt_sel;
    logic    ord_we;
    logic    ord_re;
    ow_sel_e ow_sel;
    logic    stk_we;
    logic    stk_re;
    sw_sel_e sw_sel;
    logic    best_step;
    logic    best_first;
    logic    ld_o_best;
    logic    ld_o;
    logic    ld_a;
    logic    ld_b;
    logic    a_from_b;
    logic    v_ld;
    logic    w_ld;
    logic    u_ld;
    logic    u_from_w;
    logic    emit;
    logic    emit_zero;
    logic    emit_last;
    logic    emit_ovf;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cross_gt;
    logic cross_eq;
    logic dist_lt;
    logic out_full;
  } stat_t;

endpackage

[src/chgs_datapath.sv]
// Datapath: point, order and stack stores, orientation unit and output register.
module chgs_datapath import chgs_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned IW = $clog2(MAX_POINTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic [IW-1:0]                pt_addr_i,
  input  logic [IW-1:0]                ord_addr_i,
  input  logic [IW-1:0]                stk_addr_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output stat_t                        stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] vertex_x_o,
  output logic signed [COORD_BITS-1:0] vertex_y_o,
  output logic                         status_o,
  output logic                         overflowed_o,
  output logic                         last_vertex_o
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W + 2;

  // Stores.
  logic signed [W-1:0] px_mem [MAX_POINTS];
  logic signed [W-1:0] py_mem [MAX_POINTS];
  logic [IW-1:0]       ord_mem [MAX_POINTS];
  logic [IW-1:0]       stk_mem [MAX_POINTS];

  logic signed [W-1:0] px_rd_q, py_rd_q;
  logic [IW-1:0]       ord_rd_q, stk_rd_q;
  logic [IW-1:0]       pt_raddr;
  logic [IW-1:0]       ord_wdata, stk_wdata;

  // Working registers.
  logic signed [W-1:0] best_x_q, best_y_q;
  logic [IW-1:0]       best_idx_q;
  logic signed [W-1:0] ox_q, oy_q, ax_q, ay_q, bx_q, by_q;
  logic [IW-1:0]       v_q, w_q, u_q;

  // Orientation unit.
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PW-1:0] c1_q, c2_q, sa1_q, sa2_q, sb1_q, sb2_q;
  logic signed [PW:0]   da_q, db_q;
  logic                 gt_q, eq_q;

  // Output register.
  logic                out_valid_q;
  logic signed [W-1:0] out_x_q, out_y_q;
  logic                out_st_q, out_ovf_q, out_last_q;

  // Point store read address selection.
  always_comb begin
    unique case (cmd_i.pt_sel)
      PA_ORD:  pt_raddr = ord_rd_q;
      PA_STK:  pt_raddr = stk_rd_q;
      default: pt_raddr = pt_addr_i;
    endcase
  end

  // Point store: written on input transfers, read with a registered port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_we) begin
      px_mem[pt_addr_i] <= point_x_i;
      py_mem[pt_addr_i] <= point_y_i;
    end
    if (cmd_i.pt_re) begin
      px_rd_q <= px_mem[pt_raddr];
      py_rd_q <= py_mem[pt_raddr];
    end
  end

  // Order store write data; the initial pass swaps the start point to the front.
  always_comb begin
    unique case (cmd_i.ow_sel)
      OW_V: ord_wdata = v_q;
      OW_W: ord_wdata = w_q;
      OW_U: ord_wdata = u_q;
      default: begin
        if (ord_addr_i == '0) begin
          ord_wdata = best_idx_q;
        end else if (ord_addr_i == best_idx_q) begin
          ord_wdata = '0;
        end else begin
          ord_wdata = ord_addr_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_we) begin
      ord_mem[ord_addr_i] <= ord_wdata;
    end
    if (cmd_i.ord_re) begin
      ord_rd_q <= ord_mem[ord_addr_i];
    end
  end

  // Hull stack store.
  assign stk_wdata = (cmd_i.sw_sel == SW_V) ? v_q : ord_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_we) begin
      stk_mem[stk_addr_i] <= stk_wdata;
    end
    if (cmd_i.stk_re) begin
      stk_rd_q <= stk_mem[stk_addr_i];
    end
  end

  // Lowest point search, least x breaking ties.
  always_ff @(posedge clk_i) begin
    if (cmd_i.best_step) begin
      if (cmd_i.best_first || (py_rd_q < best_y_q) ||
          ((py_rd_q == best_y_q) && (px_rd_q < best_x_q))) begin
        best_x_q   <= px_rd_q;
        best_y_q   <= py_rd_q;
        best_idx_q <= pt_addr_i;
      end
    end
  end

  // Operand points and index registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_o_best) begin
      ox_q <= best_x_q;
      oy_q <= best_y_q;
    end else if (cmd_i.ld_o) begin
      ox_q <= px_rd_q;
      oy_q <= py_rd_q;
    end
    if (cmd_i.ld_a) begin
      ax_q <= px_rd_q;
      ay_q <= py_rd_q;
    end else if (cmd_i.a_from_b) begin
      ax_q <= bx_q;
      ay_q <= by_q;
    end
    if (cmd_i.ld_b) begin
      bx_q <= px_rd_q;
      by_q <= py_rd_q;
    end
    if (cmd_i.v_ld) begin
      v_q <= ord_rd_q;
    end
    if (cmd_i.w_ld) begin
      w_q <= ord_rd_q;
    end
    if (cmd_i.u_ld) begin
      u_q <= ord_rd_q;
    end else if (cmd_i.u_from_w) begin
      u_q <= w_q;
    end
  end

  // Offsets from the origin operand.
  assign dax = DW'(ax_q) - DW'(ox_q);
  assign day = DW'(ay_q) - DW'(oy_q);
  assign dbx = DW'(bx_q) - DW'(ox_q);
  assign dby = DW'(by_q) - DW'(oy_q);

  // Products in the first stage, compares and sums in the second.
  always_ff @(posedge clk_i) begin
    c1_q  <= PW'(dax) * PW'(dby);
    c2_q  <= PW'(day) * PW'(dbx);
    sa1_q <= PW'(dax) * PW'(dax);
    sa2_q <= PW'(day) * PW'(day);
    sb1_q <= PW'(dbx) * PW'(dbx);
    sb2_q <= PW'(dby) * PW'(dby);
    gt_q  <= c1_q > c2_q;
    eq_q  <= c1_q == c2_q;
    da_q  <= (PW+1)'(sa1_q) + (PW+1)'(sa2_q);
    db_q  <= (PW+1)'(sb1_q) + (PW+1)'(sb2_q);
  end

  // Output register; a new result may load while the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q    <= cmd_i.emit_zero ? '0 : px_rd_q;
      out_y_q    <= cmd_i.emit_zero ? '0 : py_rd_q;
      out_st_q   <= cmd_i.emit_zero;
      out_ovf_q  <= cmd_i.emit_ovf;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign stat_o.cross_gt = gt_q;
  assign stat_o.cross_eq = eq_q;
  assign stat_o.dist_lt  = da_q < db_q;
  assign stat_o.out_full = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = out_x_q;
  assign vertex_y_o    = out_y_q;
  assign status_o      = out_st_q;
  assign overflowed_o  = out_ovf_q;
  assign last_vertex_o = out_last_q;

endmodule

[src/chgs_ctrl.sv]
// Controller: loads a set, then sequences search, sort, dedupe, scan and output, or echoes a set too small for a hull.
module chgs_ctrl import chgs_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  localparam int unsigned IW = $clog2(MAX_POINTS),
  localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          last_point_i,
  input  stat_t         stat_i,
  output cmd_t          cmd_o,
  output logic [IW-1:0] pt_addr_o,
  output logic [IW-1:0] ord_addr_o,
  output logic [IW-1:0] stk_addr_o
);

  localparam logic [CW-1:0] One  = CW'(1);
  localparam logic [CW-1:0] Two  = CW'(2);
  localparam logic [CW-1:0] Hmin = CW'(HullMin);
  localparam logic [CW-1:0] Cap  = CW'(MAX_POINTS);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, m_q, m_d, sp_q, sp_d;
  logic          ovf_q, ovf_d;
  logic          take, has_room, precedes;
  logic [CW-1:0] n_next;

  assign take     = (state_q == ST_LOAD) && in_valid_i;
  assign has_room = cnt_q < Cap;
  assign n_next   = has_room ? cnt_q + One : cnt_q;
  assign precedes = stat_i.cross_eq ? stat_i.dist_lt : stat_i.cross_gt;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (take && last_point_i) begin
          state_d = (n_next < Hmin) ? ST_ECHO_RD : ST_BEST_RD;
        end
      end
      ST_ECHO_RD:   state_d = ST_ECHO_EMIT;
      ST_ECHO_EMIT: begin
        if (!stat_i.out_full) begin
          state_d = (i_q + One == cnt_q) ? ST_DONE : ST_ECHO_RD;
        end
      end
      ST_BEST_RD:  state_d = ST_BEST_UPD;
      ST_BEST_UPD: state_d = (i_q + One == cnt_q) ? ST_ORD_INIT : ST_BEST_RD;
      ST_ORD_INIT: state_d = (i_q + One == cnt_q) ? ST_SORT_RD : ST_ORD_INIT;
      ST_SORT_RD:  state_d = (i_q >= cnt_q) ? ST_DD_CHK : ST_SORT_PT;
      ST_SORT_PT:  state_d = ST_SORT_LDA;
      ST_SORT_LDA: state_d = ST_INS_CHK;
      ST_INS_CHK:  state_d = (j_q <= One) ? ST_SORT_RD : ST_INS_RD;
      ST_INS_RD:   state_d = ST_INS_LDB;
      ST_INS_LDB:  state_d = ST_INS_W1;
      ST_INS_W1:   state_d = ST_INS_W2;
      ST_INS_W2:   state_d = ST_INS_DEC;
      ST_INS_DEC:  state_d = precedes ? ST_INS_CHK : ST_SORT_RD;
      ST_DD_CHK: begin
        if (i_q >= cnt_q) begin
          state_d = (m_q < Hmin) ? ST_DEGEN : ST_CP_RD;
        end else begin
          state_d = ST_DD_PT;
        end
      end
      ST_DD_PT:   state_d = ST_DD_LDA;
      ST_DD_LDA:  state_d = ST_DD_NEXT;
      ST_DD_NEXT: state_d = (i_q + One >= cnt_q) ? ST_DD_CHK : ST_DD_PT2;
      ST_DD_PT2:  state_d = ST_DD_LDB;
      ST_DD_LDB:  state_d = ST_DD_W1;
      ST_DD_W1:   state_d = ST_DD_W2;
      ST_DD_W2:   state_d = ST_DD_DEC;
      ST_DD_DEC:  state_d = stat_i.cross_eq ? ST_DD_NEXT : ST_DD_CHK;
      ST_DEGEN: begin
        if (!stat_i.out_full) begin
          state_d = ST_DONE;
        end
      end
      ST_CP_RD:  state_d = ST_CP_WR;
      ST_CP_WR:  state_d = (i_q == Two) ? ST_SC_CHK : ST_CP_RD;
      ST_SC_CHK: state_d = (i_q >= m_q) ? ST_OUT_RD : ST_SC_PT;
      ST_SC_PT:  state_d = ST_SC_LDB;
      ST_SC_LDB: state_d = ST_SC_TOP;
      ST_SC_TOP: state_d = (sp_q <= One) ? ST_SC_CHK : ST_SC_PT0;
      ST_SC_PT0: state_d = ST_SC_LDO;
      ST_SC_LDO: state_d = ST_SC_PT1;
      ST_SC_PT1: state_d = ST_SC_LDA;
      ST_SC_LDA: state_d = ST_SC_W1;
      ST_SC_W1:  state_d = ST_SC_W2;
      ST_SC_W2:  state_d = ST_SC_DEC;
      ST_SC_DEC: state_d = stat_i.cross_gt ? ST_SC_CHK : ST_SC_TOP;
      ST_OUT_RD: state_d = ST_OUT_PT;
      ST_OUT_PT: state_d = ST_OUT_EMIT;
      ST_OUT_EMIT: begin
        if (!stat_i.out_full) begin
          state_d = (i_q + One == sp_q) ? ST_DONE : ST_OUT_RD;
        end
      end
      ST_DONE: state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // Commands and addresses.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    pt_addr_o  = IW'(i_q);
    ord_addr_o = IW'(i_q);
    stk_addr_o = IW'(i_q);
    cmd_o.emit_ovf = ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        pt_addr_o    = IW'(cnt_q);
        cmd_o.pt_we  = take && has_room;
      end
      ST_ECHO_RD, ST_BEST_RD, ST_OUT_PT: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = (state_q == ST_OUT_PT) ? PA_STK : PA_CMD;
      end
      ST_ECHO_EMIT: begin
        cmd_o.emit      = !stat_i.out_full;
        cmd_o.emit_last = (i_q + One == cnt_q);
      end
      ST_BEST_UPD: begin
        cmd_o.best_step  = 1'b1;
        cmd_o.best_first = (i_q == '0);
      end
      ST_ORD_INIT: begin
        cmd_o.ord_we    = 1'b1;
        cmd_o.ow_sel    = OW_INIT;
        cmd_o.ld_o_best = 1'b1;
      end
      ST_SORT_RD, ST_DD_CHK: begin
        cmd_o.ord_re = (i_q < cnt_q);
      end
      ST_SORT_PT, ST_SC_PT: begin
        cmd_o.v_ld   = 1'b1;
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PA_ORD;
      end
      ST_SORT_LDA, ST_DD_LDA, ST_SC_LDA: begin
        cmd_o.ld_a = 1'b1;
      end
      ST_INS_CHK: begin
        if (j_q <= One) begin
          ord_addr_o   = IW'(j_q);
          cmd_o.ord_we = 1'b1;
          cmd_o.ow_sel = OW_V;
        end else begin
          ord_addr_o   = IW'(j_q - One);
          cmd_o.ord_re = 1'b1;
        end
      end
      ST_INS_RD, ST_DD_PT2: begin
        cmd_o.w_ld   = 1'b1;
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PA_ORD;
      end
      ST_INS_LDB, ST_DD_LDB, ST_SC_LDB: begin
        cmd_o.ld_b = 1'b1;
      end
      ST_INS_DEC: begin
        ord_addr_o   = IW'(j_q);
        cmd_o.ord_we = 1'b1;
        cmd_o.ow_sel = precedes ? OW_W : OW_V;
      end
      ST_DD_PT: begin
        cmd_o.u_ld   = 1'b1;
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PA_ORD;
      end
      ST_DD_NEXT: begin
        if (i_q + One >= cnt_q) begin
          ord_addr_o   = IW'(m_q);
          cmd_o.ord_we = 1'b1;
          cmd_o.ow_sel = OW_U;
        end else begin
          ord_addr_o   = IW'(i_q + One);
          cmd_o.ord_re = 1'b1;
        end
      end
      ST_DD_DEC: begin
        if (stat_i.cross_eq) begin
          cmd_o.u_from_w = 1'b1;
          cmd_o.a_from_b = 1'b1;
        end else begin
          ord_addr_o   = IW'(m_q);
          cmd_o.ord_we = 1'b1;
          cmd_o.ow_sel = OW_U;
        end
      end
      ST_DEGEN: begin
        cmd_o.emit      = !stat_i.out_full;
        cmd_o.emit_zero = 1'b1;
        cmd_o.emit_last = 1'b1;
      end
      ST_CP_RD, ST_SC_CHK: begin
        cmd_o.ord_re = 1'b1;
      end
      ST_CP_WR: begin
        cmd_o.stk_we = 1'b1;
        cmd_o.sw_sel = SW_ORD;
      end
      ST_SC_TOP: begin
        if (sp_q <= One) begin
          stk_addr_o   = IW'(sp_q);
          cmd_o.stk_we = 1'b1;
          cmd_o.sw_sel = SW_V;
        end else begin
          stk_addr_o   = IW'(sp_q - Two);
          cmd_o.stk_re = 1'b1;
        end
      end
      ST_SC_PT0, ST_SC_PT1: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PA_STK;
      end
      ST_SC_LDO: begin
        cmd_o.ld_o   = 1'b1;
        stk_addr_o   = IW'(sp_q - One);
        cmd_o.stk_re = 1'b1;
      end
      ST_SC_DEC: begin
        stk_addr_o   = IW'(sp_q);
        cmd_o.stk_we = stat_i.cross_gt;
        cmd_o.sw_sel = SW_V;
      end
      ST_OUT_RD: begin
        cmd_o.stk_re = 1'b1;
      end
      ST_OUT_EMIT: begin
        cmd_o.emit      = !stat_i.out_full;
        cmd_o.emit_last = (i_q + One == sp_q);
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  // Loop counters.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    i_d   = i_q;
    j_d   = j_q;
    m_d   = m_q;
    sp_d  = sp_q;
    unique case (state_q)
      ST_LOAD: begin
        if (take) begin
          cnt_d = n_next;
          ovf_d = ovf_q | ~has_room;
          i_d   = '0;
        end
      end
      ST_ECHO_EMIT, ST_OUT_EMIT: begin
        if (!stat_i.out_full) begin
          i_d = i_q + One;
        end
      end
      ST_BEST_UPD: i_d = (i_q + One == cnt_q) ? '0 : i_q + One;
      ST_ORD_INIT: i_d = (i_q + One == cnt_q) ? Two : i_q + One;
      ST_SORT_RD: begin
        j_d = i_q;
        if (i_q >= cnt_q) begin
          i_d = One;
          m_d = One;
        end
      end
      ST_INS_CHK: begin
        if (j_q <= One) begin
          i_d = i_q + One;
        end
      end
      ST_INS_DEC: begin
        if (precedes) begin
          j_d = j_q - One;
        end else begin
          i_d = i_q + One;
        end
      end
      ST_DD_CHK: begin
        if (i_q >= cnt_q) begin
          i_d = '0;
        end
      end
      ST_DD_NEXT: begin
        if (i_q + One >= cnt_q) begin
          m_d = m_q + One;
          i_d = i_q + One;
        end
      end
      ST_DD_DEC: begin
        i_d = i_q + One;
        if (!stat_i.cross_eq) begin
          m_d = m_q + One;
        end
      end
      ST_CP_WR: begin
        i_d = i_q + One;
        if (i_q == Two) begin
          sp_d = Hmin;
        end
      end
      ST_SC_CHK: begin
        if (i_q >= m_q) begin
          i_d = '0;
        end
      end
      ST_SC_TOP: begin
        if (sp_q <= One) begin
          sp_d = sp_q + One;
          i_d  = i_q + One;
        end
      end
      ST_SC_DEC: begin
        if (stat_i.cross_gt) begin
          sp_d = sp_q + One;
          i_d  = i_q + One;
        end else begin
          sp_d = sp_q - One;
        end
      end
      ST_DONE: begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      sp_q    <= sp_d;
    end
  end

endmodule

[src/convex_hull_graham_scan.sv]
// Top level of the Graham-scan convex hull block.
// Points are taken one per cycle until the transfer marked last_point; the block then stops
// taking input while it finds the lowest point, sorts the rest by angle with an insertion
// sort (up to n*n/2 comparisons), removes collinear runs and runs the stack scan, all
// through single-address order and stack stores, a point store with separate write and
// read addresses, and one two-stage orientation unit. Hull vertices then leave one at a
// time, each waiting while the output register is full; sets of fewer than three points
// are echoed in the same way.
module convex_hull_graham_scan import chgs_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] vertex_x_o,
  output logic signed [COORD_BITS-1:0] vertex_y_o,
  output logic                         status_o,
  output logic                         overflowed_o,
  output logic                         last_vertex_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);

  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] pt_addr, ord_addr, stk_addr;

  // Sequencer.
  chgs_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_point_i(last_point_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .pt_addr_o   (pt_addr),
    .ord_addr_o  (ord_addr),
    .stk_addr_o  (stk_addr)
  );

  // Stores and arithmetic.
  chgs_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pt_addr_i    (pt_addr),
    .ord_addr_i   (ord_addr),
    .stk_addr_i   (stk_addr),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .vertex_x_o   (vertex_x_o),
    .vertex_y_o   (vertex_y_o),
    .status_o     (status_o),
    .overflowed_o (overflowed_o),
    .last_vertex_o(last_vertex_o)
  );

endmodule
